>>> design/hvri_pkg.sv
// Shared types, constants and the arctangent table for the heading/velocity integrator.
package hvri_pkg;

    // Sequencer states of the top level
    typedef enum logic [4:0] {
        S_IDLE,
        S_GOAL,
        S_SLEW,
        S_ZHI,
        S_ZLO,
        S_TDIV,
        S_Q0,
        S_Q1,
        S_Q2,
        S_Z,
        S_CSTART,
        S_CWAIT,
        S_SD,
        S_MX,
        S_MY,
        S_PY,
        S_DONE
    } hvri_state_t;

    // Status of the rotation unit
    typedef struct packed {
        logic busy;
        logic done;
    } hvri_cordic_stat_t;

    // Register indexes on the configuration channel
    localparam logic [1:0] CFG_ACCEL_RATE     = 2'd0;
    localparam logic [1:0] CFG_VELOCITY_LIMIT = 2'd1;

    localparam logic [14:0] ACCEL_RESET  = 15'd51;
    localparam logic [14:0] VLIMIT_RESET = 15'd25600;

    // Heading in 1/64 degree
    localparam logic signed [16:0] QUARTER_TURN = 17'sd5760;
    localparam logic signed [16:0] HALF_TURN    = 17'sd11520;
    localparam logic signed [16:0] FULL_TURN    = 17'sd23040;

    // Angle to Q2.30 radians: pi*2^30 = 11520*Z_COEF_HI + Z_COEF_LO
    localparam logic [18:0] Z_COEF_HI = 19'd292817;
    localparam logic [12:0] Z_COEF_LO = 13'd7586;
    localparam logic [25:0] Z_ROUND   = 26'd5760;
    // x/45 ~ (x*RECIP_45) >> 24, low by at most one
    localparam logic [18:0] RECIP_45  = 19'd372827;
    localparam logic [5:0]  DIV_45    = 6'd45;

    // Start vector: 1/K in Q2.30
    localparam logic signed [32:0] CORDIC_GAIN = 33'sd652032874;

    // atan(2^-i) in Q2.30, truncated
    function automatic logic [29:0] atan_q30(input logic [4:0] idx);
        logic [29:0] v;
        case (idx)
            5'd0:    v = 30'h3243F6A8;
            5'd1:    v = 30'h1DAC6705;
            5'd2:    v = 30'h0FADBAFC;
            5'd3:    v = 30'h07F56EA6;
            5'd4:    v = 30'h03FEAB76;
            5'd5:    v = 30'h01FFD55B;
            5'd6:    v = 30'h00FFFAAA;
            5'd7:    v = 30'h007FFF55;
            5'd8:    v = 30'h003FFFEA;
            5'd9:    v = 30'h001FFFFD;
            5'd10:   v = 30'h000FFFFF;
            5'd11:   v = 30'h0007FFFF;
            5'd12:   v = 30'h0003FFFF;
            5'd13:   v = 30'h0001FFFF;
            5'd14:   v = 30'h0000FFFF;
            5'd15:   v = 30'h00007FFF;
            5'd16:   v = 30'h00003FFF;
            5'd17:   v = 30'h00001FFF;
            5'd18:   v = 30'h00000FFF;
            5'd19:   v = 30'h000007FF;
            5'd20:   v = 30'h000003FF;
            5'd21:   v = 30'h000001FF;
            5'd22:   v = 30'h000000FF;
            5'd23:   v = 30'h0000007F;
            default: v = 30'h0;
        endcase
        return v;
    endfunction

endpackage

>>> design/hvri_cordic.sv
// Iterative rotation-mode CORDIC: one micro-rotation per clock.
module hvri_cordic
    import hvri_pkg::*;
#(
    parameter int STEPS = 16
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic signed [32:0]       z_in,
    output hvri_cordic_stat_t        stat,
    output logic signed [32:0]       x_out,
    output logic signed [32:0]       y_out
);

    localparam int ITER_W = (STEPS > 1) ? $clog2(STEPS) : 1;
    localparam logic [ITER_W-1:0] LAST_ITER = ITER_W'(STEPS - 1);

    logic signed [32:0] x_reg, y_reg, z_reg;
    logic signed [32:0] x_next, y_next, z_next;
    logic signed [32:0] x_sh, y_sh, ang;
    logic [ITER_W-1:0]  iter_reg;
    logic               busy_reg, done_reg;

    // shared barrel shift, floor semantics
    assign x_sh = x_reg >>> iter_reg;
    assign y_sh = y_reg >>> iter_reg;
    assign ang  = $signed({3'b000, atan_q30(5'(iter_reg))});

    always_comb begin
        if (!z_reg[32]) begin
            x_next = x_reg - y_sh;
            y_next = y_reg + x_sh;
            z_next = z_reg - ang;
        end else begin
            x_next = x_reg + y_sh;
            y_next = y_reg - x_sh;
            z_next = z_reg + ang;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            iter_reg <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            iter_reg <= '0;
        end else if (busy_reg) begin
            iter_reg <= iter_reg + 1'b1;
            if (iter_reg == LAST_ITER) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            x_reg <= CORDIC_GAIN;
            y_reg <= '0;
            z_reg <= z_in;
        end else if (busy_reg) begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign x_out     = x_reg;
    assign y_out     = y_reg;

endmodule

>>> design/heading_velocity_ramp_integrator_core.sv
// Top level: slew-limited dead-reckoning integrator with sequencer and shared multiplier.
//
// Each input beat is one time step. The block adds speed_offset to the goal speed and
// clamps it to +/-velocity_limit, adds turn_offset to the heading and wraps it once into
// +/-180 degrees, slews the current speed toward the goal by (accel_rate*time_step)>>12
// without overshoot, then moves x/y by speed*cos/sin(heading)*time_step >> 34 with
// saturation. One result beat follows each input beat. A small sequencer drives one
// registered 33x33 signed multiplier (slew amount, degree-to-radian scaling and its
// division by 45, speed*time, and the two position products) and one iterative CORDIC
// that computes sine and cosine. With no back-pressure, the next input beat is taken only
// after the sequencer has stepped through every state for the previous beat, loaded its
// result into the output register and returned to S_IDLE, where s_tready is raised again.
// s_tready is high only while no item is in work; the result sits in an output register,
// so a new beat is accepted while that result still waits for m_tready. Configuration
// writes are always taken (cfg_ready is tied high) and should only be issued while idle;
// an index beyond the two registers is ignored. Reset is synchronous, active low, and
// clears speed, goal, heading and position to zero.
module heading_velocity_ramp_integrator_core
    import hvri_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
) (
    input  logic          aclk,
    input  logic          aresetn,
    // input stream
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [47:0]   s_tdata,   // time_step[15:0], speed_offset[31:16],
                                     // turn_offset[46:32], zero pad[47]
    // result stream
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [111:0]  m_tdata,   // pos_x[31:0], pos_y[63:32], speed_now[79:64],
                                     // speed_goal[95:80], heading[110:96], zero pad[111]
    // configuration writes
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [1:0]    cfg_index,
    input  logic [14:0]   cfg_data
);

    localparam logic signed [33:0] POS_MAX = 34'sd2147483647;
    localparam logic signed [33:0] POS_MIN = -34'sd2147483648;
    // pi/2 in Q2.30, bound on the rotation angle
    localparam logic signed [32:0] Z_MAX   = 33'sd1686629713;

    hvri_state_t state_reg, state_next;

    // config
    logic [14:0]        accel_reg, vlim_reg;
    // item fields
    logic [15:0]        dt_reg;
    logic signed [15:0] dv_reg;
    logic signed [14:0] da_reg;
    // integrator state
    logic signed [15:0] goal_reg, cur_reg;
    logic signed [14:0] head_reg;
    logic signed [31:0] posx_reg, posy_reg;
    // working registers
    logic signed [65:0] prod_reg;
    logic [12:0]        mag_reg;
    logic               fneg_reg, zneg_reg;
    logic [30:0]        zhi_reg;
    logic [17:0]        t_reg;
    logic [11:0]        q0_reg, qlo_reg;
    logic signed [32:0] z_reg;
    logic signed [31:0] sd_reg;
    // output register
    logic               m_tvalid_reg;
    logic [111:0]       m_tdata_reg;

    // sequencer outputs
    logic               accept, cord_start, out_load;
    logic signed [32:0] op_a, op_b;

    hvri_cordic_stat_t  cord_stat;
    logic signed [32:0] cord_x, cord_y, cos_val, sin_val;

    // ---------------- datapath comb ----------------
    logic signed [17:0] gsum, lim18, nlim18;
    logic signed [15:0] goal_new;
    logic signed [16:0] hsum, hwrap;
    logic signed [20:0] cur21, goal21, slew21, up21, dn21;
    logic signed [15:0] cur_new;
    logic signed [16:0] head17, hfold, mag17;
    logic               fneg_new;
    logic [25:0]        tsum;
    logic [17:0]        rem;
    logic [11:0]        qlo_new;
    logic [31:0]        zmag;
    logic signed [32:0] zsgn, z_new;
    logic signed [33:0] px_sum, py_sum;

    function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
        logic signed [31:0] r;
        if (v > POS_MAX) begin
            r = 32'sh7FFFFFFF;
        end else if (v < POS_MIN) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // goal: add offset, clamp to +/- limit
    assign gsum   = {{2{goal_reg[15]}}, goal_reg} + {{2{dv_reg[15]}}, dv_reg};
    assign lim18  = $signed({3'b000, vlim_reg});
    assign nlim18 = -lim18;
    always_comb begin
        if (gsum > lim18) begin
            goal_new = lim18[15:0];
        end else if (gsum < nlim18) begin
            goal_new = nlim18[15:0];
        end else begin
            goal_new = gsum[15:0];
        end
    end

    // heading: add, wrap once
    assign hsum = {{2{head_reg[14]}}, head_reg} + {{2{da_reg[14]}}, da_reg};
    always_comb begin
        if (hsum < -HALF_TURN) begin
            hwrap = hsum + FULL_TURN;
        end else if (hsum > HALF_TURN) begin
            hwrap = hsum - FULL_TURN;
        end else begin
            hwrap = hsum;
        end
    end

    // speed slew, no overshoot
    assign cur21  = {{5{cur_reg[15]}}, cur_reg};
    assign goal21 = {{5{goal_reg[15]}}, goal_reg};
    assign slew21 = {2'b00, prod_reg[30:12]};
    assign up21   = cur21 + slew21;
    assign dn21   = cur21 - slew21;
    always_comb begin
        if (goal21 > cur21) begin
            cur_new = (up21 > goal21) ? goal_reg : up21[15:0];
        end else if (goal21 < cur21) begin
            cur_new = (dn21 < goal21) ? goal_reg : dn21[15:0];
        end else begin
            cur_new = cur_reg;
        end
    end

    // fold heading into +/-90 degrees
    assign head17 = {{2{head_reg[14]}}, head_reg};
    always_comb begin
        if (head17 > QUARTER_TURN) begin
            hfold    = head17 - HALF_TURN;
            fneg_new = 1'b1;
        end else if (head17 < -QUARTER_TURN) begin
            hfold    = head17 + HALF_TURN;
            fneg_new = 1'b1;
        end else begin
            hfold    = head17;
            fneg_new = 1'b0;
        end
    end
    assign mag17 = hfold[16] ? -hfold : hfold;

    // rounded low part of the radian scaling: (mag*7586 + 5760) / 11520
    assign tsum    = prod_reg[25:0] + Z_ROUND;
    assign rem     = t_reg - (18'(q0_reg) * 18'(DIV_45));
    assign qlo_new = q0_reg + 12'(rem >= 18'(DIV_45));
    assign zmag    = {1'b0, zhi_reg} + {20'd0, qlo_reg};
    assign zsgn    = $signed({1'b0, zmag});
    assign z_new   = zneg_reg ? -zsgn : zsgn;

    assign cos_val = fneg_reg ? -cord_x : cord_x;
    assign sin_val = fneg_reg ? -cord_y : cord_y;

    assign px_sum = {{2{posx_reg[31]}}, posx_reg} + {{2{prod_reg[65]}}, prod_reg[65:34]};
    assign py_sum = {{2{posy_reg[31]}}, posy_reg} + {{2{prod_reg[65]}}, prod_reg[65:34]};

    // ---------------- sequencer ----------------
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:   if (s_tvalid) state_next = S_GOAL;
            S_GOAL:   state_next = S_SLEW;
            S_SLEW:   state_next = S_ZHI;
            S_ZHI:    state_next = S_ZLO;
            S_ZLO:    state_next = S_TDIV;
            S_TDIV:   state_next = S_Q0;
            S_Q0:     state_next = S_Q1;
            S_Q1:     state_next = S_Q2;
            S_Q2:     state_next = S_Z;
            S_Z:      state_next = S_CSTART;
            S_CSTART: state_next = S_CWAIT;
            S_CWAIT:  if (cord_stat.done) state_next = S_SD;
            S_SD:     state_next = S_MX;
            S_MX:     state_next = S_MY;
            S_MY:     state_next = S_PY;
            S_PY:     state_next = S_DONE;
            S_DONE:   if (!m_tvalid_reg || m_tready) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_comb begin
        s_tready   = 1'b0;
        cord_start = 1'b0;
        out_load   = 1'b0;
        op_a       = '0;
        op_b       = '0;
        case (state_reg)
            S_IDLE: s_tready = 1'b1;
            S_GOAL: begin
                op_a = $signed({18'd0, accel_reg});
                op_b = $signed({17'd0, dt_reg});
            end
            S_ZHI: begin
                op_a = $signed({20'd0, mag_reg});
                op_b = $signed({14'd0, Z_COEF_HI});
            end
            S_ZLO: begin
                op_a = $signed({20'd0, mag_reg});
                op_b = $signed({20'd0, Z_COEF_LO});
            end
            S_Q0: begin
                op_a = $signed({15'd0, t_reg});
                op_b = $signed({14'd0, RECIP_45});
            end
            S_CSTART: cord_start = 1'b1;
            S_SD: begin
                op_a = {{17{cur_reg[15]}}, cur_reg};
                op_b = $signed({17'd0, dt_reg});
            end
            S_MX: begin
                op_a = prod_reg[32:0];
                op_b = cos_val;
            end
            S_MY: begin
                op_a = {sd_reg[31], sd_reg};
                op_b = sin_val;
            end
            S_DONE: out_load = !m_tvalid_reg || m_tready;
            default: ;
        endcase
    end

    assign accept = s_tvalid && s_tready;

    // ---------------- registers ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            accel_reg <= ACCEL_RESET;
            vlim_reg  <= VLIMIT_RESET;
        end else if (cfg_valid) begin
            if (cfg_index == CFG_ACCEL_RATE) begin
                accel_reg <= cfg_data;
            end else if (cfg_index == CFG_VELOCITY_LIMIT) begin
                vlim_reg <= cfg_data;
            end
        end
    end

    // integrator state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            goal_reg <= '0;
            cur_reg  <= '0;
            head_reg <= '0;
            posx_reg <= '0;
            posy_reg <= '0;
        end else begin
            case (state_reg)
                S_GOAL: begin
                    goal_reg <= goal_new;
                    head_reg <= hwrap[14:0];
                end
                S_SLEW: cur_reg  <= cur_new;
                S_MY:   posx_reg <= sat32(px_sum);
                S_PY:   posy_reg <= sat32(py_sum);
                default: ;
            endcase
        end
    end

    // working registers, no reset needed
    always_ff @(posedge aclk) begin
        prod_reg <= op_a * op_b;
        if (accept) begin
            dt_reg <= s_tdata[15:0];
            dv_reg <= s_tdata[31:16];
            da_reg <= s_tdata[46:32];
        end
        case (state_reg)
            S_SLEW: begin
                mag_reg  <= mag17[12:0];
                fneg_reg <= fneg_new;
                zneg_reg <= hfold[16];
            end
            S_ZLO:  zhi_reg <= prod_reg[30:0];
            S_TDIV: t_reg   <= tsum[25:8];
            S_Q1:   q0_reg  <= prod_reg[35:24];
            S_Q2:   qlo_reg <= qlo_new;
            S_Z:    z_reg   <= z_new;
            S_MX:   sd_reg  <= prod_reg[31:0];
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tdata_reg <= {1'b0, head_reg, goal_reg, cur_reg, posy_reg, posx_reg};
        end
    end

    hvri_cordic #(
        .STEPS (CORDIC_STEPS)
    ) u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cord_start),
        .z_in    (z_reg),
        .stat    (cord_stat),
        .x_out   (cord_x),
        .y_out   (cord_y)
    );

    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign cfg_ready = 1'b1;

    // ---------------- checks ----------------
    a_head_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (head_reg >= -15'sd11520) && (head_reg <= 15'sd11520))
        else $error("heading left the wrapped range");

    a_goal_clamped: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SLEW) |->
            ($signed({2'b00, goal_reg}) <= lim18) && ($signed({2'b00, goal_reg}) >= nlim18)
            || ($signed({{2{goal_reg[15]}}, goal_reg}) <= lim18
                && $signed({{2{goal_reg[15]}}, goal_reg}) >= nlim18))
        else $error("goal speed outside the limit");

    a_no_overshoot: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_ZHI) |->
            (($past(cur_reg) <= goal_reg) ?
                (cur_reg <= goal_reg && cur_reg >= $past(cur_reg)) :
                (cur_reg >= goal_reg && cur_reg <= $past(cur_reg))))
        else $error("speed slew overshot the goal");

    a_angle_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CSTART) |-> (z_reg <= Z_MAX) && (z_reg >= -Z_MAX))
        else $error("rotation angle beyond a quarter turn");

    a_idle_cordic: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !cord_stat.busy)
        else $error("input taken while rotation unit busy");

endmodule
